[src/dfa_all_start_states_acceptance_core_defines.svh]
// Assertion macros shared by the DFA acceptance core.
`ifndef DFA_ALL_START_STATES_ACCEPTANCE_CORE_DEFINES_SVH
`define DFA_ALL_START_STATES_ACCEPTANCE_CORE_DEFINES_SVH

// Concurrent assertion that is switched off while reset is held.
`define DFAAS_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is checked at every clock edge, reset included.
`define DFAAS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/dfaas_pkg.sv]
// Types and constants shared by the DFA acceptance core.
package dfaas_pkg;

    localparam int REQ_W  = 2;
    localparam int SYM_W  = 5;
    localparam int IDX_W  = 6;
    localparam int NUMS_W = 7;
    localparam int MASK_W = 64;

    localparam logic [NUMS_W-1:0] NUMS_RESET = 7'd64;

    typedef enum logic [REQ_W-1:0] {
        OP_TRANS = 2'd0,
        OP_FLAG  = 2'd1,
        OP_STEP  = 2'd2,
        OP_EOS   = 2'd3
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [SYM_W-1:0] sym;
        logic [IDX_W-1:0] sidx;
        logic [IDX_W-1:0] nxt;
        logic             abit;
    } t_cmd;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RUN,
        BK_LOAD
    } t_back_state;

endpackage

[src/dfa_all_start_states_acceptance_core.sv]
// Top level of the DFA core that runs every start state in its own lane and reports acceptance.
//
//   channel  direction  handshake                  payload
//   input    in         i_valid / o_ready          i_req_type, i_symbol, i_state_index,
//                                                  i_next_state, i_accept_bit
//   result   out        o_valid / i_ready          o_accept_mask
//   config   in         i_cfg_valid / o_cfg_ready  i_cfg_num_states
//
// Table and flag writes are done by the execution unit straight from its idle state.
// A symbol is run in steps: a start, one issue per lane, the last lane passing the table or
// flag memory and going back to its lane, and a check that the sweep is drained.
// An end of string then hands its mask to the output register once that register can take it.
// Reset is synchronous and needs no clearing pass; lanes come out of reset at identity.
// The two-word queue takes up to two input words while a lane sweep runs or a result waits.
`include "dfa_all_start_states_acceptance_core_defines.svh"

module dfa_all_start_states_acceptance_core import dfaas_pkg::*; #(
    parameter int MAX_STATES = 64,
    parameter int ALPHABET   = 26
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [REQ_W-1:0]  i_req_type,
    input  logic [SYM_W-1:0]  i_symbol,
    input  logic [IDX_W-1:0]  i_state_index,
    input  logic [IDX_W-1:0]  i_next_state,
    input  logic              i_accept_bit,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [MASK_W-1:0] o_accept_mask,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [NUMS_W-1:0] i_cfg_num_states
);

    logic              q_ready;
    logic              push;
    t_cmd              front_cmd;
    logic              q_valid;
    t_cmd              q_cmd;
    logic              pop;
    logic              back_res_valid;
    logic              back_res_ready;
    logic [MASK_W-1:0] back_res_mask;
    logic              res_handoff;
    logic [MASK_W-1:0] out_high;

    logic [NUMS_W-1:0] r_num_states;
    logic              r_out_vld;
    logic [MASK_W-1:0] r_out_mask;

    dfaas_front #(
        .MAX_STATES (MAX_STATES),
        .ALPHABET   (ALPHABET)
    ) u_front (
        .i_valid       (i_valid),
        .i_req_type    (i_req_type),
        .i_symbol      (i_symbol),
        .i_state_index (i_state_index),
        .i_next_state  (i_next_state),
        .i_accept_bit  (i_accept_bit),
        .i_q_ready     (q_ready),
        .o_ready       (o_ready),
        .o_push        (push),
        .o_cmd         (front_cmd)
    );

    dfaas_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (pop)
    );

    dfaas_back #(
        .MAX_STATES (MAX_STATES),
        .ALPHABET   (ALPHABET)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_num_states (r_num_states),
        .i_cmd_valid  (q_valid),
        .i_cmd        (q_cmd),
        .o_pop        (pop),
        .o_res_valid  (back_res_valid),
        .o_res_mask   (back_res_mask),
        .i_res_ready  (back_res_ready)
    );

    assign o_cfg_ready    = 1'b1;
    assign back_res_ready = !r_out_vld || i_ready;
    assign res_handoff    = back_res_valid && back_res_ready;
    assign o_valid        = r_out_vld;
    assign o_accept_mask  = r_out_mask;
    assign out_high       = o_accept_mask >> r_num_states;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_states <= NUMS_RESET;
            r_out_vld    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_num_states <= i_cfg_num_states;
            end
            if (res_handoff) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_handoff) begin
            r_out_mask <= back_res_mask;
        end
    end

    `DFAAS_ASSERT_RST(a_res_lands, i_clk, i_rst_n, res_handoff |=> o_valid, "result not loaded")
    `DFAAS_ASSERT_RST(a_mask_in_range, i_clk, i_rst_n, o_valid |-> out_high == '0, "mask too wide")
    `DFAAS_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !o_valid, "valid after reset")

endmodule

[src/dfaas_front.sv]
// Front end: decodes an input word and drops requests whose fields are out of range.
module dfaas_front import dfaas_pkg::*; #(
    parameter int MAX_STATES = 64,
    parameter int ALPHABET   = 26
) (
    input  logic             i_valid,
    input  logic [REQ_W-1:0] i_req_type,
    input  logic [SYM_W-1:0] i_symbol,
    input  logic [IDX_W-1:0] i_state_index,
    input  logic [IDX_W-1:0] i_next_state,
    input  logic             i_accept_bit,
    input  logic             i_q_ready,
    output logic             o_ready,
    output logic             o_push,
    output t_cmd             o_cmd
);

    logic sym_ok;
    logic sidx_ok;
    logic nxt_ok;
    logic keep;
    t_op  op;

    assign op      = t_op'(i_req_type);
    assign sym_ok  = int'(i_symbol) < ALPHABET;
    assign sidx_ok = int'(i_state_index) < MAX_STATES;
    assign nxt_ok  = int'(i_next_state) < MAX_STATES;

    always_comb begin
        unique case (op)
            OP_TRANS: keep = sym_ok && sidx_ok && nxt_ok;
            OP_FLAG:  keep = sidx_ok;
            OP_STEP:  keep = sym_ok;
            OP_EOS:   keep = 1'b1;
            default:  keep = 1'b0;
        endcase
    end

    // Dropped words are still taken from the channel so that they do not block it.
    assign o_ready = i_q_ready;
    assign o_push  = i_valid && i_q_ready && keep;

    assign o_cmd.op   = op;
    assign o_cmd.sym  = i_symbol;
    assign o_cmd.sidx = i_state_index;
    assign o_cmd.nxt  = i_next_state;
    assign o_cmd.abit = i_accept_bit;

endmodule

[src/dfaas_queue.sv]
// Two-entry command queue between the front end and the execution unit.
module dfaas_queue import dfaas_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_ready,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

[src/dfaas_back.sv]
// Execution unit: holds the transition table, accept flags and lane states, one lane per cycle.
module dfaas_back import dfaas_pkg::*; #(
    parameter int MAX_STATES = 64,
    parameter int ALPHABET   = 26
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [NUMS_W-1:0] i_num_states,
    input  logic              i_cmd_valid,
    input  t_cmd              i_cmd,
    output logic              o_pop,
    output logic              o_res_valid,
    output logic [MASK_W-1:0] o_res_mask,
    input  logic              i_res_ready
);

    localparam int SW     = $clog2(MAX_STATES);
    localparam int SYMW   = $clog2(ALPHABET);
    localparam int TAW    = SYMW + SW;
    localparam int TDEPTH = ALPHABET * (2 ** SW);

    t_back_state r_state;
    t_back_state n_state;

    t_op              r_op;
    logic [SYMW-1:0]  r_sym;
    logic             r_issue;
    logic [SW-1:0]    r_cnt;
    logic             r_s1_vld;
    logic [SW-1:0]    r_s1_idx;
    logic             r_s2_vld;
    logic [SW-1:0]    r_s2_idx;
    logic [MAX_STATES-1:0] r_lane_vld;
    logic [MAX_STATES-1:0] r_mask;

    logic [SW-1:0] table_mem [TDEPTH];
    logic          flag_mem  [MAX_STATES];
    logic [SW-1:0] lane_mem  [MAX_STATES];
    logic [SW-1:0] r_tab_q;
    logic          r_flag_q;
    logic [SW-1:0] r_lane_q;
    logic          r_lvld_q;

    logic          start;
    logic          tab_we;
    logic          flag_we;
    logic          lane_we;
    logic          clear_lanes;
    logic          drained;
    logic [SW-1:0] lane_val;
    logic [SW-1:0] q_eff;
    logic [TAW-1:0] tab_waddr;
    logic [TAW-1:0] tab_raddr;

    assign drained = !r_issue && !r_s1_vld && !r_s2_vld;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid && (i_cmd.op == OP_STEP || i_cmd.op == OP_EOS)) begin
                    n_state = BK_RUN;
                end
            end
            BK_RUN: begin
                if (drained) begin
                    n_state = (r_op == OP_EOS) ? BK_LOAD : BK_IDLE;
                end
            end
            BK_LOAD: begin
                if (i_res_ready) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        o_pop       = 1'b0;
        start       = 1'b0;
        tab_we      = 1'b0;
        flag_we     = 1'b0;
        o_res_valid = 1'b0;
        clear_lanes = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                o_pop   = i_cmd_valid;
                start   = i_cmd_valid && (i_cmd.op == OP_STEP || i_cmd.op == OP_EOS);
                tab_we  = i_cmd_valid && (i_cmd.op == OP_TRANS);
                flag_we = i_cmd_valid && (i_cmd.op == OP_FLAG);
            end
            BK_RUN: begin
                clear_lanes = drained && (r_op == OP_EOS);
            end
            BK_LOAD: begin
                o_res_valid = 1'b1;
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    assign o_res_mask = MASK_W'(r_mask);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BK_IDLE;
            r_issue    <= 1'b0;
            r_cnt      <= '0;
            r_s1_vld   <= 1'b0;
            r_s2_vld   <= 1'b0;
            r_lane_vld <= '0;
        end else begin
            r_state  <= n_state;
            r_s1_vld <= r_issue;
            r_s2_vld <= r_s1_vld;
            if (start) begin
                r_issue <= 1'b1;
                r_cnt   <= '0;
            end else if (r_issue) begin
                r_cnt <= r_cnt + SW'(1);
                if (int'(r_cnt) == MAX_STATES - 1) begin
                    r_issue <= 1'b0;
                end
            end
            // A lane that was never written since the last string holds its own index.
            if (clear_lanes) begin
                r_lane_vld <= '0;
            end else if (lane_we) begin
                r_lane_vld[r_s2_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_op  <= i_cmd.op;
            r_sym <= i_cmd.sym[SYMW-1:0];
        end
        r_s1_idx <= r_cnt;
        r_s2_idx <= r_s1_idx;
        r_lvld_q <= r_lane_vld[r_cnt];
        if (r_s2_vld && r_op == OP_EOS) begin
            r_mask[r_s2_idx] <= r_flag_q && ({1'b0, 6'(r_s2_idx)} < i_num_states);
        end
    end

    // Stage one: lane state arrives and addresses the table or the flags.
    assign lane_val  = r_lvld_q ? r_lane_q : r_s1_idx;
    assign q_eff     = (int'(lane_val) < MAX_STATES) ? lane_val : '0;
    assign tab_raddr = {r_sym, q_eff};
    assign tab_waddr = {i_cmd.sym[SYMW-1:0], i_cmd.sidx[SW-1:0]};

    // Stage two: the next state goes back to its lane.
    assign lane_we = r_s2_vld && (r_op == OP_STEP);

    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            table_mem[tab_waddr] <= i_cmd.nxt[SW-1:0];
        end
        r_tab_q <= table_mem[tab_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (flag_we) begin
            flag_mem[i_cmd.sidx[SW-1:0]] <= i_cmd.abit;
        end
        r_flag_q <= flag_mem[q_eff];
    end

    always_ff @(posedge i_clk) begin
        if (lane_we) begin
            lane_mem[r_s2_idx] <= r_tab_q;
        end
        r_lane_q <= lane_mem[r_cnt];
    end

endmodule
